// ----- hdl/bcm_pkg.sv -----
// Shared types and constants for the CPU busy-percentage monitor.
// Used by bcm_counters, bcm_divider and cpu_busy_percent_monitor; no dependencies.
`default_nettype none

package bcm_pkg;

	localparam logic [1:0] MODE_ENTER  = 2'd0;
	localparam logic [1:0] MODE_LEAVE  = 2'd1;
	localparam logic [1:0] MODE_TICK   = 2'd2;
	localparam logic [1:0] MODE_SAMPLE = 2'd3;

	localparam int          DEPTH_W   = 8;
	localparam logic [7:0]  DEPTH_MAX = 8'd255;
	localparam int          PCT_W     = 7;
	localparam logic [6:0]  PCT_FULL  = 7'd100;
	localparam logic [2:0]  CORE_ZERO = 3'd0;

	typedef struct packed {
		logic enter;
		logic leave;
		logic tick;
		logic snap;
	} cnt_evt_t;

endpackage

`default_nettype wire

// ----- hdl/bcm_counters.sv -----
// Idle nesting depth, free-running tick counters and the window deltas taken at a sample.
// Depends on bcm_pkg.
`default_nettype none

module bcm_counters
	import bcm_pkg::*;
#(
	parameter int TICK_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cnt_evt_t             evt,
	output logic     [TICK_BITS-1:0]  d_tick,
	output logic     [TICK_BITS-1:0]  d_idle
);

	logic [DEPTH_W-1:0]   idle_depth_q;
	logic [TICK_BITS-1:0] tick_count_q;
	logic [TICK_BITS-1:0] idle_tick_count_q;
	logic [TICK_BITS-1:0] last_tick_q;
	logic [TICK_BITS-1:0] last_idle_q;
	logic [TICK_BITS-1:0] d_tick_q;
	logic [TICK_BITS-1:0] d_idle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_depth_q      <= '0;
			tick_count_q      <= '0;
			idle_tick_count_q <= '0;
			last_tick_q       <= '0;
			last_idle_q       <= '0;
		end else begin
			if (evt.enter && idle_depth_q != DEPTH_MAX) begin
				idle_depth_q <= idle_depth_q + 1'b1;
			end
			if (evt.leave && idle_depth_q != '0) begin
				idle_depth_q <= idle_depth_q - 1'b1;
			end
			if (evt.tick) begin
				tick_count_q <= tick_count_q + 1'b1;
				if (idle_depth_q != '0) begin
					idle_tick_count_q <= idle_tick_count_q + 1'b1;
				end
			end
			if (evt.snap) begin
				last_tick_q <= tick_count_q;
				last_idle_q <= idle_tick_count_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt.snap) begin
			d_tick_q <= tick_count_q - last_tick_q;
			d_idle_q <= idle_tick_count_q - last_idle_q;
		end
	end

	assign d_tick = d_tick_q;
	assign d_idle = d_idle_q;

endmodule

`default_nettype wire

// ----- hdl/bcm_divider.sv -----
// Bit-serial scaler and restoring divider: (busy*100 + den/2) / den, one dividend bit per cycle.
// Depends on bcm_pkg.
`default_nettype none

module bcm_divider
	import bcm_pkg::*;
#(
	parameter int TICK_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [TICK_BITS-1:0] busy,
	input  wire logic [TICK_BITS-1:0] den,
	output logic                      done,
	output logic      [PCT_W-1:0]     quotient
);

	localparam int DW = TICK_BITS + 7;
	localparam int CW = $clog2(DW + 1);

	typedef enum logic [3:0] {
		DV_IDLE = 4'b0001,
		DV_MUL  = 4'b0010,
		DV_HALF = 4'b0100,
		DV_STEP = 4'b1000
	} dv_state_t;

	dv_state_t            state_q;
	logic [CW-1:0]        cnt_q;
	logic                 done_q;
	logic [TICK_BITS-1:0] busy_q;
	logic [TICK_BITS-1:0] den_q;
	logic [DW-1:0]        acc_q;
	logic [TICK_BITS-1:0] rem_q;
	logic [PCT_W-1:0]     quo_q;

	logic [TICK_BITS:0]   trial;
	logic [TICK_BITS:0]   diff;
	logic                 fits;

	always_comb begin
		trial = {rem_q, acc_q[DW-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				DV_IDLE: begin
					if (start) begin
						state_q <= DV_MUL;
					end
				end
				DV_MUL: begin
					state_q <= DV_HALF;
				end
				DV_HALF: begin
					state_q <= DV_STEP;
					cnt_q   <= CW'(DW);
				end
				DV_STEP: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						state_q <= DV_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= DV_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			DV_IDLE: begin
				if (start) begin
					busy_q <= busy;
					den_q  <= den;
					acc_q  <= {1'b0, busy, 6'b0} + {2'b0, busy, 5'b0};
				end
			end
			DV_MUL: begin
				acc_q <= acc_q + {5'b0, busy_q, 2'b0};
			end
			DV_HALF: begin
				acc_q <= acc_q + {8'b0, den_q[TICK_BITS-1:1]};
				rem_q <= '0;
				quo_q <= '0;
			end
			DV_STEP: begin
				acc_q <= {acc_q[DW-2:0], 1'b0};
				quo_q <= {quo_q[PCT_W-2:0], fits};
				rem_q <= fits ? diff[TICK_BITS-1:0] : trial[TICK_BITS-1:0];
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ----- hdl/cpu_busy_percent_monitor.sv -----
// Top level of the CPU busy-percentage monitor: event intake, sample sequencer, result register.
// Depends on bcm_pkg, bcm_counters and bcm_divider.
`default_nettype none

// Each transaction on the input carries one event. Enter idle, leave idle and timer tick are
// taken whenever no sample is in progress; a sample for a nonexistent core is also held until
// the output register is free, and it returns an empty window on the next cycle. A sample for
// core 0 stalls the input until its result is written to the output register. The deltas
// are registered, the busy share is scaled by 100 in two shift-add steps, the rounding half
// is added, and a restoring divider then consumes one dividend bit per cycle, after which the
// done flag is registered and the result is written. The divider dominates the time a sample
// takes. A sample over a window with no ticks skips the divider and goes from the delta state
// straight to the result write. The result sits in an output register, so events keep
// flowing while a result waits to be taken; a later core 0 sample holds in its last state,
// with the input stalled, until that register is free.
module cpu_busy_percent_monitor
	import bcm_pkg::*;
#(
	parameter int TICK_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         mode,
	input  wire logic [2:0]         core_index,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic      [PCT_W-1:0]   busy_percent,
	output logic                    empty_window
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DELTA = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t               state_q;
	logic                 empty_q;
	logic                 out_valid_q;
	logic [PCT_W-1:0]     busy_percent_q;
	logic                 empty_window_q;

	logic                 out_free;
	logic                 accept;
	logic                 bad_sample;
	cnt_evt_t             evt;
	logic [TICK_BITS-1:0] d_tick;
	logic [TICK_BITS-1:0] d_idle;
	logic [TICK_BITS:0]   busy_diff;
	logic [TICK_BITS-1:0] busy_span;
	logic                 window_zero;
	logic                 div_start;
	logic                 div_done;
	logic [PCT_W-1:0]     quotient;

	always_comb begin
		out_free   = !out_valid_q || !out_stall;
		bad_sample = (mode == MODE_SAMPLE) && (core_index != CORE_ZERO);
		in_stall   = (state_q != ST_IDLE) || (bad_sample && !out_free);
		accept     = in_valid && !in_stall;
		evt.enter  = accept && (mode == MODE_ENTER);
		evt.leave  = accept && (mode == MODE_LEAVE);
		evt.tick   = accept && (mode == MODE_TICK);
		evt.snap   = accept && (mode == MODE_SAMPLE) && (core_index == CORE_ZERO);
		busy_diff  = {1'b0, d_tick} - {1'b0, d_idle};
		busy_span  = busy_diff[TICK_BITS] ? '0 : busy_diff[TICK_BITS-1:0];
		window_zero = (d_tick == '0);
		div_start  = (state_q == ST_DELTA) && !window_zero;
	end

	bcm_counters #(
		.TICK_BITS(TICK_BITS)
	) u_counters (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt),
		.d_tick (d_tick),
		.d_idle (d_idle)
	);

	bcm_divider #(
		.TICK_BITS(TICK_BITS)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.busy     (busy_span),
		.den      (d_tick),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			empty_q     <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && bad_sample) begin
						out_valid_q <= 1'b1;
					end
					if (evt.snap) begin
						state_q <= ST_DELTA;
					end
				end
				ST_DELTA: begin
					empty_q <= window_zero;
					state_q <= window_zero ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && bad_sample) begin
			busy_percent_q <= '0;
			empty_window_q <= 1'b1;
		end else if (state_q == ST_DONE && out_free) begin
			busy_percent_q <= empty_q ? '0 : quotient;
			empty_window_q <= empty_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign busy_percent = busy_percent_q;
	assign empty_window = empty_window_q;

`ifndef SYNTH
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state is not one-hot");

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input taken while a sample is in progress");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (busy_percent_q <= PCT_FULL))
		else $error("busy percentage above 100");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && empty_window_q) |-> (busy_percent_q == '0))
		else $error("empty window carries a nonzero percentage");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide phase");
`endif

endmodule

`default_nettype wire
